// ===== src/assert_macros.svh =====
// Assertion macros for the pulse width byte receiver.
// Included by the top level; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define PWBR_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define PWBR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/pwbr_pkg.sv =====
// Shared constants, codes and types of the pulse width byte receiver.
// No dependencies.
package pwbr_pkg;

  localparam int PULSE_W    = 32;
  localparam int REG_W      = 16;
  localparam int NUM_REGS   = 8;
  localparam int REG_IDX_W  = 3;
  localparam int NUM_WIN    = 6;
  localparam int BYTE_W     = 8;
  localparam int BIT_IDX_W  = 4;
  localparam int EVENT_W    = 3;
  localparam int LINK_W     = 2;
  localparam int CLS_W      = 3;

  localparam logic [BIT_IDX_W-1:0] FRAME_BITS = 4'd9;
  localparam logic [BIT_IDX_W-1:0] BIT_MAX    = 4'd15;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_ONE    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ZERO   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_START  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ACK    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_NACK   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_STOP   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_MBELOW = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_MABOVE = 3'd7;

  localparam logic [NUM_REGS-1:0][REG_W-1:0] REG_RESET = {
    16'd200, 16'd200, 16'd3000, 16'd4200, 16'd3600, 16'd2400, 16'd600, 16'd1200
  };

  // pulse classes
  localparam logic [CLS_W-1:0] CLS_NONE  = 3'd0;
  localparam logic [CLS_W-1:0] CLS_ONE   = 3'd1;
  localparam logic [CLS_W-1:0] CLS_ZERO  = 3'd2;
  localparam logic [CLS_W-1:0] CLS_START = 3'd3;
  localparam logic [CLS_W-1:0] CLS_ACK   = 3'd4;
  localparam logic [CLS_W-1:0] CLS_NACK  = 3'd5;
  localparam logic [CLS_W-1:0] CLS_STOP  = 3'd6;

  // result events
  localparam logic [EVENT_W-1:0] EV_NONE       = 3'd0;
  localparam logic [EVENT_W-1:0] EV_BYTE_ACK   = 3'd1;
  localparam logic [EVENT_W-1:0] EV_BYTE_DROP  = 3'd2;
  localparam logic [EVENT_W-1:0] EV_LEN_NACK   = 3'd3;
  localparam logic [EVENT_W-1:0] EV_PAR_NACK   = 3'd4;
  localparam logic [EVENT_W-1:0] EV_ACK_SEEN   = 3'd5;
  localparam logic [EVENT_W-1:0] EV_NACK_SEEN  = 3'd6;

  // partner status
  localparam logic [LINK_W-1:0] LINK_IDLE    = 2'd0;
  localparam logic [LINK_W-1:0] LINK_ACKED   = 2'd1;
  localparam logic [LINK_W-1:0] LINK_REFUSED = 2'd2;

  typedef struct packed {
    logic [NUM_WIN-1:0][REG_W-1:0] width;
    logic [REG_W-1:0]              margin_below;
    logic [REG_W-1:0]              margin_above;
  } cfg_t;

endpackage

// ===== src/pwbr_cfg.sv =====
// Configuration register file: nominal widths and margins.
// Depends on pwbr_pkg.
module pwbr_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [pwbr_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [pwbr_pkg::REG_W-1:0]     cfg_data,
  output pwbr_pkg::cfg_t                 cfg
);

  logic [pwbr_pkg::NUM_REGS-1:0][pwbr_pkg::REG_W-1:0] regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= pwbr_pkg::REG_RESET;
    end else if (cfg_write) begin
      regs[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    cfg.width[pwbr_pkg::REG_ONE]   = regs[pwbr_pkg::REG_ONE];
    cfg.width[pwbr_pkg::REG_ZERO]  = regs[pwbr_pkg::REG_ZERO];
    cfg.width[pwbr_pkg::REG_START] = regs[pwbr_pkg::REG_START];
    cfg.width[pwbr_pkg::REG_ACK]   = regs[pwbr_pkg::REG_ACK];
    cfg.width[pwbr_pkg::REG_NACK]  = regs[pwbr_pkg::REG_NACK];
    cfg.width[pwbr_pkg::REG_STOP]  = regs[pwbr_pkg::REG_STOP];
    cfg.margin_below               = regs[pwbr_pkg::REG_MBELOW];
    cfg.margin_above               = regs[pwbr_pkg::REG_MABOVE];
  end

endmodule

// ===== src/pwbr_classify.sv =====
// Window compare of one pulse against the six nominal widths, first hit wins.
// Depends on pwbr_pkg.
module pwbr_classify (
  input  logic [pwbr_pkg::PULSE_W-1:0] pulse_width,
  input  pwbr_pkg::cfg_t               cfg,
  output logic [pwbr_pkg::CLS_W-1:0]   cls
);

  localparam int BOUND_W = pwbr_pkg::REG_W + 1;
  localparam int PAD_W   = pwbr_pkg::PULSE_W - BOUND_W;

  logic [pwbr_pkg::NUM_WIN-1:0] hit;

  always_comb begin
    logic [BOUND_W-1:0] lo;
    logic [BOUND_W-1:0] hi;
    logic               lo_neg;
    for (int i = 0; i < pwbr_pkg::NUM_WIN; i++) begin
      lo_neg = cfg.width[i] < cfg.margin_below;
      lo     = {1'b0, cfg.width[i]} - {1'b0, cfg.margin_below};
      hi     = {1'b0, cfg.width[i]} + {1'b0, cfg.margin_above};
      hit[i] = (lo_neg || ({{PAD_W{1'b0}}, lo} < pulse_width)) &&
               (pulse_width < {{PAD_W{1'b0}}, hi});
    end
  end

  always_comb begin
    if (hit[pwbr_pkg::REG_ONE]) begin
      cls = pwbr_pkg::CLS_ONE;
    end else if (hit[pwbr_pkg::REG_ZERO]) begin
      cls = pwbr_pkg::CLS_ZERO;
    end else if (hit[pwbr_pkg::REG_START]) begin
      cls = pwbr_pkg::CLS_START;
    end else if (hit[pwbr_pkg::REG_ACK]) begin
      cls = pwbr_pkg::CLS_ACK;
    end else if (hit[pwbr_pkg::REG_NACK]) begin
      cls = pwbr_pkg::CLS_NACK;
    end else if (hit[pwbr_pkg::REG_STOP]) begin
      cls = pwbr_pkg::CLS_STOP;
    end else begin
      cls = pwbr_pkg::CLS_NONE;
    end
  end

endmodule

// ===== src/pwbr_frame.sv =====
// Frame state (bit count, shift byte, parity, partner status) and result register.
// Depends on pwbr_pkg.
module pwbr_frame (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            advance,
  input  logic [pwbr_pkg::CLS_W-1:0]      cls,
  input  logic                            room,
  input  logic                            taken,
  output logic                            out_valid,
  output logic [pwbr_pkg::EVENT_W-1:0]    event_res,
  output logic [pwbr_pkg::BYTE_W-1:0]     byte_out,
  output logic [pwbr_pkg::LINK_W-1:0]     link_status
);

  logic [pwbr_pkg::BIT_IDX_W-1:0] bit_index, bit_index_next;
  logic [pwbr_pkg::BYTE_W-1:0]    shift_byte, shift_byte_next;
  logic                           ones_parity, ones_parity_next;
  logic [pwbr_pkg::LINK_W-1:0]    partner_status, partner_status_next;
  logic [pwbr_pkg::EVENT_W-1:0]   event_next;
  logic [pwbr_pkg::BYTE_W-1:0]    byte_next;
  logic [pwbr_pkg::BIT_IDX_W-1:0] bit_count;

  assign bit_count = (bit_index == pwbr_pkg::BIT_MAX) ? bit_index
                                                      : bit_index + 4'd1;

  always_comb begin
    bit_index_next      = bit_index;
    shift_byte_next     = shift_byte;
    ones_parity_next    = ones_parity;
    partner_status_next = partner_status;
    event_next          = pwbr_pkg::EV_NONE;
    byte_next           = '0;
    unique case (cls)
      pwbr_pkg::CLS_ONE: begin
        if (!bit_index[pwbr_pkg::BIT_IDX_W-1]) begin
          shift_byte_next[bit_index[pwbr_pkg::BIT_IDX_W-2:0]] = 1'b1;
        end
        ones_parity_next = ~ones_parity;
        bit_index_next   = bit_count;
      end
      pwbr_pkg::CLS_ZERO: begin
        bit_index_next = bit_count;
      end
      pwbr_pkg::CLS_START: begin
        bit_index_next   = '0;
        shift_byte_next  = '0;
        ones_parity_next = 1'b0;
      end
      pwbr_pkg::CLS_ACK: begin
        partner_status_next = pwbr_pkg::LINK_ACKED;
        event_next          = pwbr_pkg::EV_ACK_SEEN;
      end
      pwbr_pkg::CLS_NACK: begin
        partner_status_next = pwbr_pkg::LINK_REFUSED;
        event_next          = pwbr_pkg::EV_NACK_SEEN;
      end
      pwbr_pkg::CLS_STOP: begin
        if (bit_index != pwbr_pkg::FRAME_BITS) begin
          event_next = pwbr_pkg::EV_LEN_NACK;
        end else if (ones_parity) begin
          event_next = pwbr_pkg::EV_PAR_NACK;
        end else if (room) begin
          event_next = pwbr_pkg::EV_BYTE_ACK;
          byte_next  = shift_byte;
        end else begin
          event_next = pwbr_pkg::EV_BYTE_DROP;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_index      <= '0;
      shift_byte     <= '0;
      ones_parity    <= 1'b0;
      partner_status <= pwbr_pkg::LINK_IDLE;
      out_valid      <= 1'b0;
    end else begin
      if (advance) begin
        bit_index      <= bit_index_next;
        shift_byte     <= shift_byte_next;
        ones_parity    <= ones_parity_next;
        partner_status <= partner_status_next;
        out_valid      <= 1'b1;
      end else if (taken) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      event_res   <= event_next;
      byte_out    <= byte_next;
      link_status <= partner_status_next;
    end
  end

endmodule

// ===== src/pulse_width_byte_receiver.sv =====
// Pulse width byte receiver: input register, window classifier, frame state.
// Depends on pwbr_pkg, pwbr_cfg, pwbr_classify, pwbr_frame, assert_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_stall) carries one measured pulse per
//   transaction: pulse_width and sink_has_room. Output channel
//   (out_valid/out_stall) returns exactly one transaction per pulse:
//   event_res, byte_out and link_status.
//   Configuration: cfg_write with cfg_index/cfg_data writes one of eight
//   16-bit registers; write only while the block is idle.
//   Path: a taken pulse is held in the input register, and its result is
//   then registered in the output register.
//   Throughput: one pulse per cycle while out_stall is low; the window
//   compare and frame update sit between the input and output registers.
//   Stall: while out_stall holds a result, one more pulse can wait in the
//   input register; in_stall rises only when both registers are full.
//   Reset: synchronous; clears the frame state, partner status and both
//   valid flags, and restores the register defaults.
`include "assert_macros.svh"

module pulse_width_byte_receiver (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [pwbr_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [pwbr_pkg::REG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [pwbr_pkg::PULSE_W-1:0]   pulse_width,
  input  logic                           sink_has_room,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pwbr_pkg::EVENT_W-1:0]   event_res,
  output logic [pwbr_pkg::BYTE_W-1:0]    byte_out,
  output logic [pwbr_pkg::LINK_W-1:0]    link_status
);

  pwbr_pkg::cfg_t                 cfg;
  logic                           s1_valid;
  logic [pwbr_pkg::PULSE_W-1:0]   s1_pulse;
  logic                           s1_room;
  logic [pwbr_pkg::CLS_W-1:0]     s1_cls;
  logic                           out_free;
  logic                           advance;
  logic                           taken;
  logic                           in_take;

  assign taken    = out_valid && !out_stall;
  assign out_free = !out_valid || !out_stall;
  assign advance  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_pulse <= pulse_width;
      s1_room  <= sink_has_room;
    end
  end

  pwbr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pwbr_classify u_classify (
    .pulse_width (s1_pulse),
    .cfg         (cfg),
    .cls         (s1_cls)
  );

  pwbr_frame u_frame (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .cls         (s1_cls),
    .room        (s1_room),
    .taken       (taken),
    .out_valid   (out_valid),
    .event_res   (event_res),
    .byte_out    (byte_out),
    .link_status (link_status)
  );

  `PWBR_ASSERT_ALWAYS(a_stall_cause, clk, in_stall |-> (s1_valid && out_valid && out_stall), "in_stall without a full pipeline")
  `PWBR_ASSERT(a_byte_only_on_ack, clk, rst, (out_valid && event_res != pwbr_pkg::EV_BYTE_ACK) |-> (byte_out == '0), "byte_out nonzero without accepted byte")
  `PWBR_ASSERT(a_ack_status, clk, rst, (out_valid && event_res == pwbr_pkg::EV_ACK_SEEN) |-> (link_status == pwbr_pkg::LINK_ACKED), "ack event without acked status")
  `PWBR_ASSERT(a_result_holds, clk, rst, (out_valid && out_stall && !s1_valid) |=> (out_valid && $stable(event_res)), "stalled result lost")

endmodule
